### sv/cpsc_pkg.sv
// ----------------------------------------------------------------------------
// CMYK shadow classifier package
// Pixel transfer types, class codes, register indexes and threshold slots.
// ----------------------------------------------------------------------------
package cpsc_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [1:0] pixel_class;
  } out_pix_t;

  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_YELLOW = 2'd1;
  localparam logic [1:0] CLS_BLACK  = 2'd2;

  // register select is byte address bit 2
  localparam logic REG_MEAN_K = 1'b0;
  localparam logic REG_MEAN_Y = 1'b1;

  localparam int unsigned MEAN_K_RST = 6554;

  localparam int THR_K1_LO = 0;
  localparam int THR_K1_HI = 1;
  localparam int THR_K4    = 2;
  localparam int THR_Y1    = 3;
  localparam int THR_Y5    = 4;
  localparam int THR_N     = 5;

endpackage

### sv/cmyk_pixel_shadow_classifier.sv
// ----------------------------------------------------------------------------
// CMYK pixel shadow classifier
// RGB to CMYK conversion and rule chain that forces yellow, black or keeps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one RGB pixel per
//   transfer; output channel out_valid/out_stall/out_data carries the
//   result pixel and its class (unchanged, forced yellow, forced black).
//   The APB port writes mean_k (byte address 0) and mean_y (address 4)
//   as fractions scaled by 2^FRAC_BITS; write them only while idle.
//   A new write applies to pixels accepted at the same edge or later.
//   Throughput: one pixel per cycle while out_stall is low, through the
//   four-stage pipeline (capture, max and reciprocal lookup, reciprocal
//   multiply, compare).
//   When out_stall is high a valid output register holds and bubbles in
//   the pipeline close up; in_stall rises only once every stage is full.
//   Reset empties the pipeline, sets mean_k to 6554 and mean_y to 0.
// ----------------------------------------------------------------------------
module cmyk_pixel_shadow_classifier #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpsc_pkg::in_pix_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cpsc_pkg::out_pix_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cpsc_pkg::*;

  localparam int W   = FRAC_BITS + 1;
  localparam int TW  = FRAC_BITS + 3;
  localparam int RSH = FRAC_BITS + 16;
  localparam int RW  = FRAC_BITS + 17;
  localparam int PW  = RW + 8;

  localparam logic [W-1:0] C05 = W'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
  localparam logic [W-1:0] C1  = W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [W-1:0] C2  = W'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [RW-1:0] R255 = RW'(((64'd1 << RSH) + 64'd254) / 64'd255);

  // configuration registers
  logic [W-1:0] mean_k_r, mean_y_r;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_k_r <= W'(MEAN_K_RST);
      mean_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MEAN_K: mean_k_r <= pwdata[W-1:0];
        REG_MEAN_Y: mean_y_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MEAN_K: prdata = 32'(mean_k_r);
      REG_MEAN_Y: prdata = 32'(mean_y_r);
      default:    prdata = '0;
    endcase
  end

  logic [THR_N-1:0][TW-1:0] thr;

  cpsc_thresh #(
    .FRAC_BITS(FRAC_BITS)
  ) u_thresh (
    .clk   (clk),
    .mean_k(mean_k_r),
    .mean_y(mean_y_r),
    .thr   (thr)
  );

  // reciprocal table: ceil(2^RSH / d), entry 0 is zero
  logic [RW-1:0] rcp_tab [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_rcp
    if (gi == 0) begin : g_zero
      assign rcp_tab[gi] = '0;
    end else begin : g_val
      localparam longint unsigned Den = gi;
      localparam logic [RW-1:0] Rv = RW'(((64'd1 << RSH) + Den - 64'd1) / Den);
      assign rcp_tab[gi] = Rv;
    end
  end

  // pipeline control
  logic va_r, vb_r, vc_r, out_valid_r;
  logic en_a, en_b, en_c, en_o;

  assign en_o     = !out_valid_r || !out_stall;
  assign en_c     = !vc_r || en_o;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a) va_r        <= in_valid;
      if (en_b) vb_r        <= va_r;
      if (en_c) vc_r        <= vb_r;
      if (en_o) out_valid_r <= vc_r;
    end
  end

  // stage A: capture pixel
  in_pix_t pix_a_r;

  always_ff @(posedge clk) begin
    if (en_a && in_valid) pix_a_r <= in_data;
  end

  // stage B: max channel, differences, reciprocal lookup
  logic [7:0]    mx_nxt;
  in_pix_t       pix_b_r;
  logic [7:0]    dc_b_r, dm_b_r, dy_b_r, dk_b_r;
  logic [RW-1:0] rcp_b_r;

  always_comb begin
    mx_nxt = pix_a_r.red_in;
    if (pix_a_r.green_in > mx_nxt) mx_nxt = pix_a_r.green_in;
    if (pix_a_r.blue_in > mx_nxt)  mx_nxt = pix_a_r.blue_in;
  end

  always_ff @(posedge clk) begin
    if (en_b && va_r) begin
      pix_b_r <= pix_a_r;
      dc_b_r  <= mx_nxt - pix_a_r.red_in;
      dm_b_r  <= mx_nxt - pix_a_r.green_in;
      dy_b_r  <= mx_nxt - pix_a_r.blue_in;
      dk_b_r  <= 8'd255 - mx_nxt;
      rcp_b_r <= rcp_tab[mx_nxt];
    end
  end

  // stage C: reciprocal multiply
  logic [PW-1:0] pc, pm, py, pk;
  in_pix_t       pix_c_r;
  logic [W-1:0]  c_c_r, m_c_r, y_c_r, k_c_r;

  always_comb begin
    pc = PW'(dc_b_r) * PW'(rcp_b_r);
    pm = PW'(dm_b_r) * PW'(rcp_b_r);
    py = PW'(dy_b_r) * PW'(rcp_b_r);
    pk = PW'(dk_b_r) * PW'(R255);
  end

  always_ff @(posedge clk) begin
    if (en_c && vb_r) begin
      pix_c_r <= pix_b_r;
      c_c_r   <= pc[16 +: W];
      m_c_r   <= pm[16 +: W];
      y_c_r   <= py[16 +: W];
      k_c_r   <= pk[16 +: W];
    end
  end

  // output stage: rule chain
  logic signed [TW-1:0] ks, ys;
  logic                 rule1, rule2, rule3, rule4, rule5;
  out_pix_t             out_nxt, out_data_r;

  always_comb begin
    ks    = $signed(TW'(k_c_r));
    ys    = $signed(TW'(y_c_r));
    rule1 = (ks > $signed(thr[THR_K1_LO])) && (ks < $signed(thr[THR_K1_HI])) &&
            (ys > $signed(thr[THR_Y1]));
    rule2 = (y_c_r < C1) && (k_c_r > C05) && (m_c_r < C2) && (c_c_r < C2);
    rule3 = (k_c_r < C2) && (m_c_r < C2) && (c_c_r < C2);
    rule4 = ks > $signed(thr[THR_K4]);
    rule5 = ys > $signed(thr[THR_Y5]);

    out_nxt.red_out     = pix_c_r.red_in;
    out_nxt.green_out   = pix_c_r.green_in;
    out_nxt.blue_out    = pix_c_r.blue_in;
    out_nxt.pixel_class = CLS_NONE;
    if (rule1) begin
      out_nxt.pixel_class = CLS_YELLOW;
    end else if (rule2) begin
      out_nxt.pixel_class = CLS_BLACK;
    end else if (rule3) begin
      out_nxt.pixel_class = CLS_YELLOW;
    end else if (rule4) begin
      out_nxt.pixel_class = CLS_BLACK;
    end else if (rule5) begin
      out_nxt.pixel_class = CLS_YELLOW;
    end

    case (out_nxt.pixel_class)
      CLS_YELLOW: begin
        out_nxt.red_out   = 8'd255;
        out_nxt.green_out = 8'd255;
        out_nxt.blue_out  = 8'd0;
      end
      CLS_BLACK: begin
        out_nxt.red_out   = 8'd0;
        out_nxt.green_out = 8'd0;
        out_nxt.blue_out  = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_o && vc_r) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/cpsc_thresh.sv
// ----------------------------------------------------------------------------
// CMYK shadow classifier thresholds
// Derive the rule thresholds from the reference black and yellow levels.
// ----------------------------------------------------------------------------
module cpsc_thresh #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                        clk,
  input  logic [FRAC_BITS:0]                          mean_k,
  input  logic [FRAC_BITS:0]                          mean_y,
  output logic [cpsc_pkg::THR_N-1:0][FRAC_BITS+2:0]   thr
);
  import cpsc_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam int MW = W + 4;
  localparam int QS = W + 5;

  localparam logic [W-1:0] C1 = W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [W-1:0] C2 = W'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [W-1:0] C3 = W'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic [MW-1:0] M10 = MW'(((64'd1 << QS) + 64'd9) / 64'd10);
  localparam logic [MW-1:0] M3  = MW'(((64'd1 << QS) + 64'd2) / 64'd3);
  localparam logic [MW-1:0] M5  = MW'(((64'd1 << QS) + 64'd4) / 64'd5);

  logic [W-1:0]      mk_nxt;
  logic [W+MW-1:0]   p10, p3, p5;
  logic [W-1:0]      mk_r, my_r;
  logic [W-2:0]      q10_r, q3_r, q5_r;
  logic [THR_N-1:0][TW-1:0] thr_nxt, thr_r;

  always_comb begin
    mk_nxt = (mean_k < C1) ? C1 : mean_k;
    p10    = (W+MW)'(mk_nxt) * (W+MW)'(M10);
    p3     = (W+MW)'(mk_nxt) * (W+MW)'(M3);
    p5     = (W+MW)'(mk_nxt) * (W+MW)'(M5);
  end

  always_ff @(posedge clk) begin
    mk_r  <= mk_nxt;
    my_r  <= mean_y;
    q10_r <= p10[QS +: W-1];
    q3_r  <= p3[QS +: W-1];
    q5_r  <= p5[QS +: W-1];
  end

  always_comb begin
    thr_nxt[THR_K1_LO] = TW'(mk_r) + TW'(q10_r);
    thr_nxt[THR_K1_HI] = TW'(mk_r) + TW'(C3) - TW'(q3_r);
    thr_nxt[THR_K4]    = TW'(mk_r) + TW'(C2) - TW'(q5_r);
    thr_nxt[THR_Y1]    = TW'(my_r) - TW'(C1);
    thr_nxt[THR_Y5]    = TW'(my_r) - TW'(my_r[W-1:1]);
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt;
  end

  assign thr = thr_r;

endmodule

### sv/cpsc_checker.sv
// ----------------------------------------------------------------------------
// CMYK shadow classifier checker
// Port-level checks on reset, stall behavior and forced result pixels.
// ----------------------------------------------------------------------------
module cpsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cpsc_pkg::out_pix_t out_data
);
  import cpsc_pkg::*;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pixel_class == CLS_BLACK |->
      out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
      out_data.blue_out == 8'd0)
    else $error("forced black pixel not black");

  a_yellow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pixel_class == CLS_YELLOW |->
      out_data.red_out == 8'd255 && out_data.green_out == 8'd255 &&
      out_data.blue_out == 8'd0)
    else $error("forced yellow pixel not yellow");

endmodule

bind cmyk_pixel_shadow_classifier cpsc_checker u_cpsc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
